[src/kcsr_pkg.sv]
// Package for the keyed cache slot replacement block.
// Holds default sizes, payload structs, controller states and the control/status bundles.
// No dependencies.
package kcsr_pkg;

	// Default sizes for the top-level parameters
	localparam int unsigned SLOTS_DEF    = 16;
	localparam int unsigned KEY_BITS_DEF = 32;
	localparam int unsigned AGE_BITS_DEF = 8;

	// Fixed payload widths
	localparam int unsigned IN_KEY_W = 32;
	localparam int unsigned SLOT_W   = 4;

	typedef enum logic {
		KIND_LOOKUP = 1'b0,
		KIND_INSERT = 1'b1
	} kind_t;

	// Request transfer
	typedef struct packed {
		kind_t               kind;
		logic [IN_KEY_W-1:0] key;
	} req_t;

	// Response transfer
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              replaced;
	} rsp_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic fin_lookup;
		logic fin_ins_empty;
		logic fin_ins_evict;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		kind_t kind;
		logic  any_empty;
		logic  scan_last;
		logic  out_free;
	} dp_stat_t;

endpackage

[src/kcsr_ctrl.sv]
// Controller state machine for the keyed cache slot replacement block.
// Sequences accept, evaluate, age scan and commit. Depends on kcsr_pkg.
module kcsr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  kcsr_pkg::dp_stat_t stat,
	output kcsr_pkg::dp_cmd_t  cmd
);
	import kcsr_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.kind == KIND_LOOKUP || stat.any_empty) begin
					if (stat.out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ST_EVAL: begin
				if (stat.kind == KIND_LOOKUP) begin
					cmd.fin_lookup = stat.out_free;
				end else if (stat.any_empty) begin
					cmd.fin_ins_empty = stat.out_free;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_COMMIT: begin
				cmd.fin_ins_evict = stat.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

[src/kcsr_dp.sv]
// Datapath for the keyed cache slot replacement block: slot registers, key compare,
// empty search, serial age-minimum scan and the response register. Depends on kcsr_pkg.
module kcsr_dp #(
	parameter int unsigned SLOTS    = kcsr_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BITS = kcsr_pkg::KEY_BITS_DEF,
	parameter int unsigned AGE_BITS = kcsr_pkg::AGE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kcsr_pkg::req_t     req,
	input  kcsr_pkg::dp_cmd_t  cmd,
	output kcsr_pkg::dp_stat_t stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output kcsr_pkg::rsp_t     rsp
);
	import kcsr_pkg::*;

	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Slot store
	logic [SLOTS-1:0]    valid_q;
	logic [KEY_BITS-1:0] key_q [SLOTS];
	logic [AGE_BITS-1:0] age_q [SLOTS];

	// Held request
	req_t                req_q;
	logic [KEY_BITS-1:0] key_w;

	// Age scan: shifted copy of the ages, position counter, running minimum
	logic [AGE_BITS-1:0] scan_age_q [SLOTS];
	logic [SW-1:0]       scan_cnt_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [SW-1:0]       best_idx_q;

	// Response register
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [SLOTS-1:0] match;
	logic             match_any;
	logic [SW-1:0]    match_idx;
	logic             empty_any;
	logic [SW-1:0]    empty_idx;
	logic             wr_en;
	logic [SW-1:0]    wr_idx;
	logic             out_free;

	// Request key trimmed or zero-extended to the stored key width
	if (KEY_BITS <= IN_KEY_W) begin : g_key_trim
		assign key_w = req_q.key[KEY_BITS-1:0];
	end else begin : g_key_ext
		assign key_w = {{(KEY_BITS-IN_KEY_W){1'b0}}, req_q.key};
	end

	// Parallel compare and lowest-index encoders
	always_comb begin
		match_idx = '0;
		empty_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_w);
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i])    match_idx = SW'(i);
			if (!valid_q[i]) empty_idx = SW'(i);
		end
		match_any = |match;
		empty_any = ~&valid_q;
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign wr_en    = cmd.fin_ins_empty || cmd.fin_ins_evict;
	assign wr_idx   = cmd.fin_ins_evict ? best_idx_q : empty_idx;

	assign stat.kind      = req_q.kind;
	assign stat.any_empty = empty_any;
	assign stat.scan_last = (scan_cnt_q == SW'(SLOTS - 1));
	assign stat.out_free  = out_free;

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Keys and ages: chosen slot loads, other valid slots age by one
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (SW'(i) == wr_idx) begin
					key_q[i] <= key_w;
					age_q[i] <= '1;
				end else if (valid_q[i] && (age_q[i] != '0)) begin
					age_q[i] <= age_q[i] - 1'b1;
				end
			end
		end
	end

	// Minimum-age scan, one slot per cycle, first slot wins ties
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			for (int i = 0; i < SLOTS; i++) scan_age_q[i] <= age_q[i];
			scan_cnt_q <= '0;
		end else if (cmd.scan_step) begin
			for (int i = 0; i < SLOTS - 1; i++) scan_age_q[i] <= scan_age_q[i+1];
			scan_cnt_q <= scan_cnt_q + 1'b1;
			if ((scan_cnt_q == '0) || (scan_age_q[0] < best_age_q)) begin
				best_age_q <= scan_age_q[0];
				best_idx_q <= scan_cnt_q;
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.fin_lookup || wr_en) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_lookup) begin
			rsp_q.hit      <= match_any;
			rsp_q.slot     <= match_any ? SLOT_W'(match_idx) : '0;
			rsp_q.replaced <= 1'b0;
		end else if (wr_en) begin
			rsp_q.hit      <= 1'b0;
			rsp_q.slot     <= SLOT_W'(wr_idx);
			rsp_q.replaced <= cmd.fin_ins_evict;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/keyed_cache_slot_replacement.sv]
// Keyed cache slot replacement: fully associative tag store with age-based eviction.
// Lookup, and insert into an empty slot: the request is held, evaluated in ST_EVAL and its
// response registered once the response register is free. Insert into a full store: ST_EVAL,
// then the serial minimum-age scan in ST_SCAN (one slot per cycle), then the write in ST_COMMIT.
// One item in flight; the response register lets the next request transfer while a response
// is stalled. arst_n empties every slot.
module keyed_cache_slot_replacement #(
	parameter int unsigned SLOTS    = kcsr_pkg::SLOTS_DEF,
	parameter int unsigned KEY_BITS = kcsr_pkg::KEY_BITS_DEF,
	parameter int unsigned AGE_BITS = kcsr_pkg::AGE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  kcsr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output kcsr_pkg::rsp_t rsp
);
	import kcsr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller
	kcsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath
	kcsr_dp #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS),
		.AGE_BITS (AGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// One item in flight: busy right after a request transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while an item is in flight");

	// A new response only follows an accepted item
	a_rsp_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without an item in flight");

	// Hit and eviction never reported together
	a_hit_xor_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.replaced))
		else $error("response reports both hit and eviction");

	// At most one finish or scan start per cycle
	a_single_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fin_lookup, cmd.fin_ins_empty, cmd.fin_ins_evict, cmd.scan_start}))
		else $error("conflicting datapath commands");

endmodule

[tb/sv/tb.sv]
// Testbench for keyed_cache_slot_replacement: directed and random lookup/insert traffic.
// Checks every response against a local model of the slot store, including random and long
// response back-pressure. Depends on kcsr_pkg and the keyed_cache_slot_replacement RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcsr_pkg::*;

	localparam int unsigned SLOTS     = SLOTS_DEF;
	localparam int unsigned KEY_BITS  = KEY_BITS_DEF;
	localparam int unsigned AGE_BITS  = AGE_BITS_DEF;
	localparam logic [AGE_BITS-1:0] AGE_TOP = '1;
	localparam int unsigned LONG_HOLD = 80;
	localparam int unsigned DRAIN_CYC = 4 * (SLOTS + 3);
	localparam int unsigned POOL_MAX  = 24;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	keyed_cache_slot_replacement #(
		.SLOTS(SLOTS),
		.KEY_BITS(KEY_BITS),
		.AGE_BITS(AGE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Model of the slot store
	logic                slot_used [SLOTS];
	logic [KEY_BITS-1:0] slot_tag  [SLOTS];
	logic [AGE_BITS-1:0] slot_stamp[SLOTS];

	rsp_t        rsp_expect_q[$];
	logic [31:0] key_pool[$];
	int unsigned errors;
	int unsigned req_count;
	int unsigned rsp_count;
	int unsigned evict_count;
	int unsigned hit_count;
	bit          calm;
	bit          hold_request;

	function automatic void store_clear();
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i]  = 1'b0;
			slot_tag[i]   = '0;
			slot_stamp[i] = '0;
		end
	endfunction

	// Predict one response and update the modeled store
	function automatic rsp_t store_predict(req_t r);
		rsp_t                o;
		logic [KEY_BITS-1:0] k;
		int                  pick;
		logic                found;
		logic [AGE_BITS-1:0] best;
		o     = '0;
		k     = r.key[KEY_BITS-1:0];
		found = 1'b0;
		pick  = 0;
		if (r.kind == KIND_LOOKUP) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && slot_used[i] && slot_tag[i] == k) begin
					found = 1'b1;
					pick  = i;
				end
			end
			o.hit  = found;
			o.slot = found ? pick[SLOT_W-1:0] : '0;
			return o;
		end
		// lowest empty slot first
		for (int i = 0; i < SLOTS; i++) begin
			if (!found && !slot_used[i]) begin
				found = 1'b1;
				pick  = i;
			end
		end
		o.replaced = !found;
		// otherwise strictly smallest age, lowest index on a tie
		if (!found) begin
			best = slot_stamp[0];
			for (int i = 1; i < SLOTS; i++) begin
				if (slot_stamp[i] < best) begin
					best = slot_stamp[i];
					pick = i;
				end
			end
		end
		slot_used[pick]  = 1'b1;
		slot_tag[pick]   = k;
		slot_stamp[pick] = AGE_TOP;
		for (int i = 0; i < SLOTS; i++) begin
			if (i != pick && slot_used[i] && slot_stamp[i] != '0)
				slot_stamp[i] = slot_stamp[i] - 1'b1;
		end
		o.slot = pick[SLOT_W-1:0];
		return o;
	endfunction

	// Transfer monitor: predict on request transfer, check on response transfer
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				rsp_expect_q.push_back(store_predict(req));
				req_count++;
			end
			if (rsp_valid && !rsp_stall) begin
				rsp_count++;
				if (rsp_expect_q.size() == 0) begin
					$display("%0t: unexpected response hit=%0b slot=%0d replaced=%0b",
						$time, rsp.hit, rsp.slot, rsp.replaced);
					errors++;
				end else begin
					want = rsp_expect_q.pop_front();
					if (rsp.hit !== want.hit) begin
						$display("%0t: hit mismatch: expected %0b, actual %0b",
							$time, want.hit, rsp.hit);
						errors++;
					end
					if (rsp.slot !== want.slot) begin
						$display("%0t: slot mismatch: expected %0d, actual %0d",
							$time, want.slot, rsp.slot);
						errors++;
					end
					if (rsp.replaced !== want.replaced) begin
						$display("%0t: replaced mismatch: expected %0b, actual %0b",
							$time, want.replaced, rsp.replaced);
						errors++;
					end
					if (want.replaced)
						evict_count++;
					if (want.hit)
						hit_count++;
				end
			end
		end
	end

	// Response side: random stall bursts, plus one long hold on request
	initial begin
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offer one request and return at the edge of its transfer; valid stays high
	task automatic send_item(input req_t item);
		logic taken;
		req       <= item;
		req_valid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !req_stall;
			@(posedge clk);
		end
	endtask

	task automatic send_req(input kind_t kind, input logic [31:0] key);
		req_t item;
		item.kind = kind;
		item.key  = key;
		send_item(item);
	endtask

	task automatic idle_burst(input int unsigned cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Random request: mostly keys seen before, so lookups hit and inserts duplicate
	function automatic req_t random_req();
		req_t        r;
		int unsigned pick;
		pick   = $urandom_range(0, 9);
		r.kind = ($urandom_range(0, 1) == 0) ? KIND_LOOKUP : KIND_INSERT;
		if (pick == 0)
			r.key = 32'h0000_0000;
		else if (pick == 1)
			r.key = 32'hFFFF_FFFF;
		else if (pick < 6 && key_pool.size() != 0)
			r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else
			r.key = $urandom;
		if (r.kind == KIND_INSERT) begin
			key_pool.push_back(r.key);
			if (key_pool.size() > POOL_MAX)
				void'(key_pool.pop_front());
		end
		return r;
	endfunction

	// Lookups on an empty store miss at both key extremes
	task automatic test_empty_lookup();
		send_req(KIND_LOOKUP, 32'h0000_0000);
		send_req(KIND_LOOKUP, 32'hFFFF_FFFF);
	endtask

	// Fill every empty slot in order, no eviction
	task automatic test_fill_empty_slots();
		logic [31:0] k;
		for (int i = 0; i < SLOTS; i++) begin
			case (i)
				0: k = 32'h0000_0000;
				1: k = 32'hFFFF_FFFF;
				2: k = 32'h8000_0000;
				3: k = 32'h0000_0001;
				default: k = 32'hA5A5_0000 | i;
			endcase
			send_req(KIND_INSERT, k);
			key_pool.push_back(k);
		end
	endtask

	// Hits at both extremes and a miss on a full store
	task automatic test_hits_and_miss();
		send_req(KIND_LOOKUP, 32'h0000_0000);
		send_req(KIND_LOOKUP, 32'hFFFF_FFFF);
		send_req(KIND_LOOKUP, 32'h5A5A_5A5A);
	endtask

	// Insert into a full store evicts the oldest slot
	task automatic test_eviction();
		send_req(KIND_INSERT, 32'h1234_5678);
		send_req(KIND_LOOKUP, 32'h0000_0000);
		send_req(KIND_LOOKUP, 32'h1234_5678);
	endtask

	// Duplicate key lands in a lower slot; lookup returns the lowest match
	task automatic test_duplicate_insert();
		send_req(KIND_INSERT, 32'hA5A5_0005);
		send_req(KIND_LOOKUP, 32'hA5A5_0005);
	endtask

	task automatic test_random_traffic(input int unsigned count);
		for (int n = 0; n < count; n++) begin
			if (!calm && $urandom_range(0, 4) == 0)
				idle_burst($urandom_range(1, 4));
			send_item(random_req());
		end
	endtask

	// Receiver holds off while requests keep coming, filling the block
	task automatic test_output_backpressure();
		hold_request = 1'b1;
		for (int n = 0; n < 12; n++)
			send_item(random_req());
		req_valid <= 1'b0;
		while (hold_request)
			@(posedge clk);
	endtask

	initial begin
		errors       = 0;
		req_count    = 0;
		rsp_count    = 0;
		evict_count  = 0;
		hit_count    = 0;
		calm         = 1'b0;
		hold_request = 1'b0;
		store_clear();
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_lookup();
		test_fill_empty_slots();
		test_hits_and_miss();
		test_eviction();
		test_duplicate_insert();
		test_random_traffic(300);
		test_output_backpressure();
		calm = 1'b1;
		test_random_traffic(300);

		req_valid <= 1'b0;
		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Ran %0d requests, checked %0d responses (%0d hits, %0d evictions),",
			req_count, rsp_count, hit_count, evict_count);
		$display("with random idling on both sides and a %0d-cycle response hold-off.",
			LONG_HOLD);
		if (errors == 0) begin
			$display("keyed_cache_slot_replacement regression: pass");
		end else begin
			$display("keyed_cache_slot_replacement regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("keyed_cache_slot_replacement regression: fail");
		$finish;
	end

endmodule

[keyed_cache_slot_replacement.f]
src/kcsr_pkg.sv
src/kcsr_ctrl.sv
src/kcsr_dp.sv
src/keyed_cache_slot_replacement.sv
tb/sv/tb.sv
